>>> hdl/ipr_pkg.sv
`default_nettype none

package ipr_pkg;

  localparam int DataW       = 8;
  localparam int ColW        = 11;
  localparam int RowW        = 12;
  localparam int CfgWidthW   = 12;
  localparam int CfgHeightW  = 13;
  localparam int CfgIndexW   = 4;
  localparam int CfgDataW    = 13;

  localparam int MaxWidthDef   = 2048;
  localparam int HeightLimit   = 4096;
  localparam int DefaultWidth  = 2048;
  localparam int DefaultHeight = 2048;

  // Fewer than this many nonzero neighbours marks a pixel as isolated.
  localparam int MinNeighbours = 2;
  localparam int MaxResults    = 3;
  localparam int QueueDepth    = 8;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_FRAME_WIDTH  = 4'd0,
    CFG_FRAME_HEIGHT = 4'd1
  } cfg_idx_e;

  // One line store entry: the row above and the row two above.
  typedef struct packed {
    logic [DataW-1:0] above;
    logic [DataW-1:0] two_above;
  } line_entry_t;

  // Pixel in flight between acceptance and the window update.
  typedef struct packed {
    logic [DataW-1:0]     pix;
    logic [CfgWidthW-1:0] x;
    logic [RowW-1:0]      y;
    logic                 has_center;
    logic                 interior;
    logic                 row_end;
    logic                 bottom;
  } stage_t;

  typedef struct packed {
    logic [DataW-1:0] pixel;
    logic [ColW-1:0]  column;
    logic [RowW-1:0]  row;
    logic             last;
    logic             frame_end;
  } result_t;

endpackage

`default_nettype wire

>>> hdl/ipr_line_store.sv
`default_nettype none

module ipr_line_store #(
  parameter int MAX_WIDTH = ipr_pkg::MaxWidthDef,
  localparam int AddrW = $clog2(MAX_WIDTH)
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                rd_en_i,
  input  wire logic [AddrW-1:0]    rd_addr_i,
  input  wire logic                wr_en_i,
  input  wire logic [AddrW-1:0]    wr_addr_i,
  input  wire ipr_pkg::line_entry_t wr_data_i,
  output ipr_pkg::line_entry_t     rd_data_o
);

  ipr_pkg::line_entry_t mem [MAX_WIDTH];
  ipr_pkg::line_entry_t rd_q;
  ipr_pkg::line_entry_t wr_data_q;
  logic                 fwd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
    wr_data_q <= wr_data_i;
  end

  // A read and a write of the same entry in one cycle return the new data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_q <= wr_en_i && (rd_addr_i == wr_addr_i);
    end
  end

  assign rd_data_o = fwd_q ? wr_data_q : rd_q;

endmodule

`default_nettype wire

>>> hdl/ipr_window.sv
`default_nettype none

module ipr_window (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 stage_valid_i,
  input  wire ipr_pkg::stage_t      stage_i,
  input  wire ipr_pkg::line_entry_t column_i,
  output ipr_pkg::result_t [2:0]    res_o,
  output logic [2:0]                res_valid_o
);

  logic [ipr_pkg::DataW-1:0] win_q [9];
  logic [ipr_pkg::DataW-1:0] win_d [9];
  logic [7:0]                nz;
  logic [ipr_pkg::DataW-1:0] center;
  logic                      isolated;
  logic [ipr_pkg::CfgWidthW-1:0] x_m1;
  logic [ipr_pkg::RowW-1:0]      y_m1;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_d[r*3+0] = win_q[r*3+1];
      win_d[r*3+1] = win_q[r*3+2];
    end
    win_d[2] = column_i.two_above;
    win_d[5] = column_i.above;
    win_d[8] = stage_i.pix;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= '0;
      end
    end else if (stage_valid_i) begin
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= win_d[i];
      end
    end
  end

  always_comb begin
    nz[0] = win_d[0] != '0;
    nz[1] = win_d[1] != '0;
    nz[2] = win_d[2] != '0;
    nz[3] = win_d[3] != '0;
    nz[4] = win_d[5] != '0;
    nz[5] = win_d[6] != '0;
    nz[6] = win_d[7] != '0;
    nz[7] = win_d[8] != '0;
  end

  assign center   = win_d[4];
  assign isolated = stage_i.interior && (center != '0)
                    && ($countones(nz) < ipr_pkg::MinNeighbours);
  assign x_m1     = stage_i.x - 1'b1;
  assign y_m1     = stage_i.y - 1'b1;

  always_comb begin
    res_valid_o[0] = stage_valid_i && stage_i.has_center;
    res_valid_o[1] = stage_valid_i && stage_i.row_end && (stage_i.y != '0);
    res_valid_o[2] = stage_valid_i && stage_i.bottom;

    res_o[0].pixel     = isolated ? '0 : center;
    res_o[0].column    = x_m1[ipr_pkg::ColW-1:0];
    res_o[0].row       = y_m1;
    res_o[0].last      = !res_valid_o[1] && !res_valid_o[2];
    res_o[0].frame_end = 1'b0;

    res_o[1].pixel     = column_i.above;
    res_o[1].column    = stage_i.x[ipr_pkg::ColW-1:0];
    res_o[1].row       = y_m1;
    res_o[1].last      = !res_valid_o[2];
    res_o[1].frame_end = 1'b0;

    res_o[2].pixel     = stage_i.pix;
    res_o[2].column    = stage_i.x[ipr_pkg::ColW-1:0];
    res_o[2].row       = stage_i.y;
    res_o[2].last      = 1'b1;
    res_o[2].frame_end = stage_i.row_end;
  end

endmodule

`default_nettype wire

>>> hdl/ipr_out_queue.sv
`default_nettype none

module ipr_out_queue (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire ipr_pkg::result_t [2:0] push_data_i,
  input  wire logic [2:0]            push_valid_i,
  output logic [$clog2(ipr_pkg::QueueDepth+1)-1:0] count_o,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output ipr_pkg::result_t           out_data_o
);

  localparam int PtrW = $clog2(ipr_pkg::QueueDepth);
  localparam int CntW = $clog2(ipr_pkg::QueueDepth + 1);

  ipr_pkg::result_t entries [ipr_pkg::QueueDepth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [PtrW-1:0]  off [3];
  logic [CntW-1:0]  push_n;
  logic             pop;

  // Valid results are packed into consecutive slots in their order.
  always_comb begin
    off[0] = '0;
    off[1] = PtrW'(push_valid_i[0]);
    off[2] = PtrW'(push_valid_i[0]) + PtrW'(push_valid_i[1]);
    push_n = CntW'(push_valid_i[0]) + CntW'(push_valid_i[1]) + CntW'(push_valid_i[2]);
  end

  assign pop      = out_valid_o && out_ready_i;
  assign wr_ptr_d = wr_ptr_q + PtrW'(push_n);
  assign rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
  assign cnt_d    = cnt_q + push_n - CntW'(pop);

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      if (push_valid_i[k]) begin
        entries[wr_ptr_q + off[k]] <= push_data_i[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  assign count_o     = cnt_q;
  assign out_valid_o = cnt_q != '0;
  assign out_data_o  = entries[rd_ptr_q];

endmodule

`default_nettype wire

>>> hdl/isolated_pixel_removal.sv
`default_nettype none

// Isolated pixel removal over a raster-scanned 8-bit frame. A pixel is accepted in every
// cycle while the eight-entry output queue has room for the up to three results of the pixel
// in flight and of the one being accepted. Its results go from the stage register into the
// output queue. The output side delivers one result per cycle while out_ready_i is high, so
// ordinary rows run at one pixel per cycle, while the last row of the frame, which gives two
// results for most pixels, runs slower. Both line stores share one memory of MAX_WIDTH entries
// that is read when a pixel is accepted and written back in the cycle after, with forwarding
// when the same entry is read in that cycle. A configuration write of width or height restarts
// the frame at column 0, row 0 and should only be issued while the block is idle.
module isolated_pixel_removal #(
  parameter int MAX_WIDTH = ipr_pkg::MaxWidthDef
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [ipr_pkg::DataW-1:0]      pixel_in_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [ipr_pkg::DataW-1:0]           pixel_out_o,
  output logic [ipr_pkg::ColW-1:0]            out_column_o,
  output logic [ipr_pkg::RowW-1:0]            out_row_o,
  output logic                                last_of_item_o,
  output logic                                frame_end_o,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [ipr_pkg::CfgIndexW-1:0]  cfg_index_i,
  input  wire logic [ipr_pkg::CfgDataW-1:0]   cfg_data_i
);

  localparam int AddrW = $clog2(MAX_WIDTH);
  localparam int CntW  = $clog2(ipr_pkg::QueueDepth + 1);

  logic [ipr_pkg::CfgWidthW-1:0]  frame_width_q;
  logic [ipr_pkg::CfgHeightW-1:0] frame_height_q;
  logic [ipr_pkg::CfgWidthW-1:0]  w_eff, w_m1;
  logic [ipr_pkg::CfgHeightW-1:0] h_eff;
  logic [ipr_pkg::RowW-1:0]       h_m1;

  logic [ipr_pkg::CfgWidthW-1:0]  x_q, x_d;
  logic [ipr_pkg::RowW-1:0]       y_q, y_d;
  logic                           restart;
  logic                           accept;

  ipr_pkg::stage_t      stage_q, stage_d;
  logic                 stage_valid_q;
  ipr_pkg::line_entry_t column;
  ipr_pkg::line_entry_t wb_data;

  ipr_pkg::result_t [2:0] res;
  logic [2:0]             res_valid;
  logic [CntW-1:0]        q_count;
  ipr_pkg::result_t       q_data;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    restart = 1'b0;
    case (cfg_index_i)
      ipr_pkg::CFG_FRAME_WIDTH:  restart = cfg_valid_i;
      ipr_pkg::CFG_FRAME_HEIGHT: restart = cfg_valid_i;
      default:                   restart = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= ipr_pkg::CfgWidthW'(ipr_pkg::DefaultWidth);
      frame_height_q <= ipr_pkg::CfgHeightW'(ipr_pkg::DefaultHeight);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        ipr_pkg::CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i[ipr_pkg::CfgWidthW-1:0];
        ipr_pkg::CFG_FRAME_HEIGHT: frame_height_q <= cfg_data_i[ipr_pkg::CfgHeightW-1:0];
        default: ;
      endcase
    end
  end

  // Out-of-range sizes are clamped: zero acts as one, large values as the limit.
  always_comb begin
    if (frame_width_q == '0) begin
      w_eff = ipr_pkg::CfgWidthW'(1);
    end else if (32'(frame_width_q) > MAX_WIDTH) begin
      w_eff = ipr_pkg::CfgWidthW'(MAX_WIDTH);
    end else begin
      w_eff = frame_width_q;
    end
    if (frame_height_q == '0) begin
      h_eff = ipr_pkg::CfgHeightW'(1);
    end else if (32'(frame_height_q) > ipr_pkg::HeightLimit) begin
      h_eff = ipr_pkg::CfgHeightW'(ipr_pkg::HeightLimit);
    end else begin
      h_eff = frame_height_q;
    end
    w_m1 = w_eff - 1'b1;
    h_m1 = ipr_pkg::RowW'(h_eff - 1'b1);
  end

  // Room is kept for the pixel already in flight and for the one being accepted.
  assign in_ready_o = (int'(q_count) + (stage_valid_q ? ipr_pkg::MaxResults : 0))
                      <= (ipr_pkg::QueueDepth - ipr_pkg::MaxResults);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    x_d = x_q;
    y_d = y_q;
    if (restart) begin
      x_d = '0;
      y_d = '0;
    end else if (accept) begin
      if (x_q == w_m1) begin
        x_d = '0;
        y_d = (y_q == h_m1) ? '0 : y_q + 1'b1;
      end else begin
        x_d = x_q + 1'b1;
      end
    end
  end

  always_comb begin
    stage_d.pix        = pixel_in_i;
    stage_d.x          = x_q;
    stage_d.y          = y_q;
    stage_d.has_center = (x_q != '0) && (y_q != '0);
    stage_d.interior   = (x_q >= ipr_pkg::CfgWidthW'(2)) && (y_q >= ipr_pkg::RowW'(2));
    stage_d.row_end    = x_q == w_m1;
    stage_d.bottom     = y_q == h_m1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q           <= '0;
      y_q           <= '0;
      stage_valid_q <= 1'b0;
    end else begin
      x_q           <= x_d;
      y_q           <= y_d;
      stage_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      stage_q <= stage_d;
    end
  end

  assign wb_data.above     = stage_q.pix;
  assign wb_data.two_above = column.above;

  ipr_line_store #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (AddrW'(x_q)),
    .wr_en_i   (stage_valid_q),
    .wr_addr_i (AddrW'(stage_q.x)),
    .wr_data_i (wb_data),
    .rd_data_o (column)
  );

  ipr_window u_window (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .stage_valid_i (stage_valid_q),
    .stage_i       (stage_q),
    .column_i      (column),
    .res_o         (res),
    .res_valid_o   (res_valid)
  );

  ipr_out_queue u_out_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_data_i  (res),
    .push_valid_i (res_valid),
    .count_o      (q_count),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (q_data)
  );

  assign pixel_out_o    = q_data.pixel;
  assign out_column_o   = q_data.column;
  assign out_row_o      = q_data.row;
  assign last_of_item_o = q_data.last;
  assign frame_end_o    = q_data.frame_end;

endmodule

`default_nettype wire

>>> tb/sv/isolated_pixel_removal_tb.sv
`timescale 1ns / 100ps

module isolated_pixel_removal_tb;

  localparam int CycleLimit   = 40000;
  localparam int SettleCycles = 8;
  localparam int TailCycles   = 16;
  localparam int RandomItems  = 100;
  localparam logic [ipr_pkg::CfgIndexW-1:0] SpareIndex = {ipr_pkg::CfgIndexW{1'b1}};

  typedef enum logic [1:0] {STEP_WRITE, STEP_PIXEL, STEP_KNOWN, STEP_RUN} step_e;
  typedef enum logic [1:0] {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_MOSTLY} ready_mode_e;

  typedef struct packed {
    step_e                           kind;
    logic [ipr_pkg::CfgIndexW-1:0]   index;
    logic [ipr_pkg::CfgDataW-1:0]    value;
    logic [ipr_pkg::DataW-1:0]       pixel;
    logic [12:0]                     count;
    ipr_pkg::result_t                want;
  } step_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                          in_valid  = 1'b0;
  logic [ipr_pkg::DataW-1:0]     pixel_in  = '0;
  logic                          out_ready = 1'b0;
  logic                          cfg_valid = 1'b0;
  logic [ipr_pkg::CfgIndexW-1:0] cfg_index = '0;
  logic [ipr_pkg::CfgDataW-1:0]  cfg_data  = '0;

  logic                      in_ready;
  logic                      out_valid;
  logic [ipr_pkg::DataW-1:0] pixel_out;
  logic [ipr_pkg::ColW-1:0]  out_column;
  logic [ipr_pkg::RowW-1:0]  out_row;
  logic                      last_of_item;
  logic                      frame_end;
  logic                      cfg_ready;

  // Filter state kept alongside the block.
  logic [ipr_pkg::DataW-1:0] row_above_q     [ipr_pkg::MaxWidthDef] = '{default: '0};
  logic [ipr_pkg::DataW-1:0] row_two_above_q [ipr_pkg::MaxWidthDef] = '{default: '0};
  logic [ipr_pkg::DataW-1:0] nbhd            [9]                    = '{default: '0};
  int unsigned               col_at         = 0;
  int unsigned               row_at         = 0;
  logic [ipr_pkg::CfgWidthW-1:0]  width_setting  = ipr_pkg::CfgWidthW'(ipr_pkg::DefaultWidth);
  logic [ipr_pkg::CfgHeightW-1:0] height_setting = ipr_pkg::CfgHeightW'(ipr_pkg::DefaultHeight);

  ipr_pkg::result_t awaited [$];
  step_t            plan [$];
  int unsigned      mismatch_count = 0;
  int unsigned      cycle_count    = 0;
  int unsigned      burst_left     = 4;
  int unsigned      fill_pct       = 30;
  ready_mode_e      ready_mode     = READY_ALWAYS;
  int unsigned      mode_left      = 0;

  isolated_pixel_removal u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .pixel_in_i     (pixel_in),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .pixel_out_o    (pixel_out),
    .out_column_o   (out_column),
    .out_row_o      (out_row),
    .last_of_item_o (last_of_item),
    .frame_end_o    (frame_end),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic int unsigned active_width();
    if (width_setting == 0) return 1;
    if (width_setting > ipr_pkg::MaxWidthDef) return ipr_pkg::MaxWidthDef;
    return width_setting;
  endfunction

  function automatic int unsigned active_height();
    if (height_setting == 0) return 1;
    if (height_setting > ipr_pkg::HeightLimit) return ipr_pkg::HeightLimit;
    return height_setting;
  endfunction

  // Steps the filter by one pixel and, if asked, queues the pixels it releases.
  function automatic void filter_pixel(input logic [ipr_pkg::DataW-1:0] pix, input bit record);
    int unsigned               w, h, x, y, idx, nbrs;
    int                        r, i, n;
    logic [ipr_pkg::DataW-1:0] centre;
    ipr_pkg::result_t          res [ipr_pkg::MaxResults];
    w = active_width();
    h = active_height();
    x = col_at;
    y = row_at;
    idx = x % ipr_pkg::MaxWidthDef;
    n = 0;
    for (r = 0; r < 3; r++) begin
      nbhd[r*3]   = nbhd[r*3+1];
      nbhd[r*3+1] = nbhd[r*3+2];
    end
    nbhd[2] = row_two_above_q[idx];
    nbhd[5] = row_above_q[idx];
    nbhd[8] = pix;
    row_two_above_q[idx] = row_above_q[idx];
    row_above_q[idx] = pix;

    if (x >= 1 && y >= 1) begin
      centre = nbhd[4];
      // The centre sits at (x-1, y-1); only pixels off the frame border are examined.
      if (centre != 0 && x >= 2 && x + 1 <= w && y >= 2 && y + 1 <= h) begin
        nbrs = 0;
        for (i = 0; i < 9; i++) begin
          if (i != 4 && nbhd[i] != 0) nbrs++;
        end
        if (nbrs < ipr_pkg::MinNeighbours) centre = '0;
      end
      res[n] = '{centre, ipr_pkg::ColW'(x - 1), ipr_pkg::RowW'(y - 1), 1'b0, 1'b0};
      n++;
    end
    if (x + 1 == w && y >= 1) begin
      res[n] = '{nbhd[5], ipr_pkg::ColW'(x), ipr_pkg::RowW'(y - 1), 1'b0, 1'b0};
      n++;
    end
    if (y + 1 == h) begin
      res[n] = '{pix, ipr_pkg::ColW'(x), ipr_pkg::RowW'(y), 1'b0, (x + 1 == w)};
      n++;
    end
    if (n > 0) res[n-1].last = 1'b1;
    if (record) begin
      for (i = 0; i < n; i++) awaited = {awaited, res[i]};
    end

    x++;
    if (x >= w) begin
      x = 0;
      y++;
      if (y >= h) y = 0;
    end
    col_at = x;
    row_at = y;
  endfunction

  function automatic logic [ipr_pkg::DataW-1:0] sparse_pixel();
    if ($urandom_range(0, 99) < fill_pct) begin
      return ipr_pkg::DataW'($urandom_range(1, (1 << ipr_pkg::DataW) - 1));
    end
    return '0;
  endfunction

  function automatic void add_write(input logic [ipr_pkg::CfgIndexW-1:0] idx,
                                    input logic [ipr_pkg::CfgDataW-1:0] data);
    step_t s;
    s = '0;
    s.kind  = STEP_WRITE;
    s.index = idx;
    s.value = data;
    plan = {plan, s};
  endfunction

  function automatic void add_pixel(input logic [ipr_pkg::DataW-1:0] pix);
    step_t s;
    s = '0;
    s.kind  = STEP_PIXEL;
    s.pixel = pix;
    plan = {plan, s};
  endfunction

  function automatic void add_known(input logic [ipr_pkg::DataW-1:0] pix,
                                    input ipr_pkg::result_t want);
    step_t s;
    s = '0;
    s.kind  = STEP_KNOWN;
    s.pixel = pix;
    s.want  = want;
    plan = {plan, s};
  endfunction

  function automatic void add_run(input int unsigned count);
    step_t s;
    s = '0;
    s.kind  = STEP_RUN;
    s.count = 13'(count);
    plan = {plan, s};
  endfunction

  task automatic report_mismatch(input string msg);
    $display("Mismatch at cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want_v, input ipr_pkg::result_t want);
    if (got !== want_v) begin
      report_mismatch($sformatf("%s of pixel (%0d,%0d): got %0h, expected %0h",
                                name, want.column, want.row, got, want_v));
    end
  endtask

  task automatic check_result();
    ipr_pkg::result_t want;
    if (awaited.size() == 0) begin
      report_mismatch($sformatf("result with nothing awaited: %0h at (%0d,%0d)",
                                pixel_out, out_column, out_row));
    end else begin
      want = awaited.pop_front();
      compare_field("pixel", 32'(pixel_out), 32'(want.pixel), want);
      compare_field("column", 32'(out_column), 32'(want.column), want);
      compare_field("row", 32'(out_row), 32'(want.row), want);
      compare_field("last flag", 32'(last_of_item), 32'(want.last), want);
      compare_field("frame end", 32'(frame_end), 32'(want.frame_end), want);
    end
  endtask

  // Output side: the stall pattern changes every so often.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_result();
    if (mode_left == 0) begin
      ready_mode = ready_mode_e'($urandom_range(0, 3));
      mode_left  = $urandom_range(8, 120);
    end
    mode_left--;
    case (ready_mode)
      READY_ALWAYS: out_ready <= 1'b1;
      READY_COIN:   out_ready <= 1'($urandom_range(0, 1));
      READY_SPARSE: out_ready <= (cycle_count % 4 == 0);
      default:      out_ready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  task automatic send_pixel(input logic [ipr_pkg::DataW-1:0] pix, input bit known,
                            input ipr_pkg::result_t want);
    int unsigned gap;
    filter_pixel(pix, !known);
    if (known) awaited = {awaited, want};
    pixel_in <= pix;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      // Now and then a long burst with no gaps at all.
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
    end
  endtask

  task automatic write_register(input logic [ipr_pkg::CfgIndexW-1:0] idx,
                                input logic [ipr_pkg::CfgDataW-1:0] data);
    in_valid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
    // Pixels that release nothing may still be on their way through the pipeline.
    repeat (SettleCycles) @(posedge clk);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == ipr_pkg::CFG_FRAME_WIDTH) begin
      width_setting = data[ipr_pkg::CfgWidthW-1:0];
      col_at = 0;
      row_at = 0;
    end else if (idx == ipr_pkg::CFG_FRAME_HEIGHT) begin
      height_setting = data;
      col_at = 0;
      row_at = 0;
    end
  endtask

  initial begin
    int unsigned fed, span, area;

    // Reset sizes first, then a frame one column wide.
    add_run(8);
    add_write(ipr_pkg::CFG_FRAME_WIDTH, 13'd1);
    add_run(6);
    // Single-pixel frames: every pixel is the last of its frame.
    add_write(ipr_pkg::CFG_FRAME_HEIGHT, 13'd1);
    add_known(8'h00, '{8'h00, '0, '0, 1'b1, 1'b1});
    add_known(8'hFF, '{8'hFF, '0, '0, 1'b1, 1'b1});
    add_write(ipr_pkg::CFG_FRAME_WIDTH, 13'd0);
    add_known(8'h5A, '{8'h5A, '0, '0, 1'b1, 1'b1});
    add_write(ipr_pkg::CFG_FRAME_HEIGHT, 13'd0);
    add_known(8'hA5, '{8'hA5, '0, '0, 1'b1, 1'b1});
    // 3x3 frames: a centre with two lit neighbours survives, one with a single one is cleared.
    add_write(ipr_pkg::CFG_FRAME_WIDTH, 13'd3);
    add_write(ipr_pkg::CFG_FRAME_HEIGHT, 13'd3);
    add_pixel(8'd0); add_pixel(8'd9);   add_pixel(8'd0);
    add_pixel(8'd0); add_pixel(8'd200); add_pixel(8'd0);
    add_pixel(8'd0); add_pixel(8'd0);   add_pixel(8'd7);
    add_pixel(8'd3); add_pixel(8'd0);   add_pixel(8'd0);
    add_pixel(8'd0);
    // A write to an unused index must not restart the frame.
    add_write(SpareIndex, 13'h1FFF);
    add_pixel(8'd44); add_pixel(8'd0);
    add_pixel(8'd0);  add_pixel(8'd0);  add_pixel(8'd0);
    // Out-of-range sizes saturate; the upper data bit is dropped for the width.
    add_write(ipr_pkg::CFG_FRAME_WIDTH, 13'h1FFF);
    add_write(ipr_pkg::CFG_FRAME_HEIGHT, 13'd1);
    add_run(12);
    add_write(ipr_pkg::CFG_FRAME_WIDTH, 13'd1);
    add_write(ipr_pkg::CFG_FRAME_HEIGHT, 13'h1FFF);
    add_run(12);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[k]) begin
      case (plan[k].kind)
        STEP_WRITE: write_register(plan[k].index, plan[k].value);
        STEP_PIXEL: send_pixel(plan[k].pixel, 1'b0, '0);
        STEP_KNOWN: send_pixel(plan[k].pixel, 1'b1, plan[k].want);
        default: begin
          repeat (plan[k].count) send_pixel(sparse_pixel(), 1'b0, '0);
        end
      endcase
    end

    fed = 0;
    while (fed < RandomItems) begin
      fill_pct = $urandom_range(0, 100);
      case ($urandom_range(0, 7))
        0: write_register(ipr_pkg::CFG_FRAME_WIDTH,
                          ipr_pkg::CfgDataW'($urandom_range(0, 10)));
        1: write_register(ipr_pkg::CFG_FRAME_HEIGHT,
                          ipr_pkg::CfgDataW'($urandom_range(0, 8)));
        2: write_register(ipr_pkg::CfgIndexW'($urandom_range(ipr_pkg::CFG_FRAME_HEIGHT + 1,
                                                             SpareIndex)),
                          ipr_pkg::CfgDataW'($urandom));
        default: begin
          write_register(ipr_pkg::CFG_FRAME_WIDTH, ipr_pkg::CfgDataW'($urandom_range(0, 10)));
          write_register(ipr_pkg::CFG_FRAME_HEIGHT, ipr_pkg::CfgDataW'($urandom_range(0, 8)));
        end
      endcase
      area = active_width() * active_height();
      // Mostly whole frames, sometimes a frame cut short by the next write.
      span = ($urandom_range(0, 3) == 0) ? $urandom_range(1, area) : area * $urandom_range(1, 2);
      if (span > 64) span = $urandom_range(1, 64);
      if (span > RandomItems - fed) span = RandomItems - fed;
      repeat (span) send_pixel(sparse_pixel(), 1'b0, '0);
      fed += span;
    end
    in_valid <= 1'b0;

    while (awaited.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> isolated_pixel_removal.f
hdl/ipr_pkg.sv
hdl/ipr_line_store.sv
hdl/ipr_window.sv
hdl/ipr_out_queue.sv
hdl/isolated_pixel_removal.sv
tb/sv/isolated_pixel_removal_tb.sv
